FILE: rtl/mrp_pkg.sv
package mrp_pkg;

   localparam int NUM_WIDTH = 64;
   localparam int CAND_WIDTH = 64;
   localparam int CNT_W = $clog2(2 * NUM_WIDTH);
   localparam int S_W = $clog2(NUM_WIDTH);
   localparam int WIT_COUNT = 7;
   localparam int WIDX_W = 3;

   typedef logic [NUM_WIDTH-1:0] num_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD3,
      ST_MOD3_WAIT,
      ST_SPLIT,
      ST_WIT,
      ST_WIT_WAIT,
      ST_POW,
      ST_POW_MUL_WAIT,
      ST_POW_SQR_WAIT,
      ST_SQ_CHECK,
      ST_SQ_WAIT,
      ST_NEXT,
      ST_DONE
   } state_type;

   // Control that the multiplier hands to every cell of its row.
   typedef struct packed {
      logic load;
      logic step;
      logic dbl;
      logic add_x;
      logic shift;
      logic use_diff;
   } cell_ctl_type;

   function automatic num_type witness(input logic [WIDX_W-1:0] idx);
      num_type w;
      unique case (idx)
         3'd0:    w = NUM_WIDTH'(32'd2);
         3'd1:    w = NUM_WIDTH'(32'd325);
         3'd2:    w = NUM_WIDTH'(32'd9375);
         3'd3:    w = NUM_WIDTH'(32'd28178);
         3'd4:    w = NUM_WIDTH'(32'd450775);
         3'd5:    w = NUM_WIDTH'(32'd9780504);
         3'd6:    w = NUM_WIDTH'(32'd1795265022);
         default: w = NUM_WIDTH'(32'd2);
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/mrp_if.sv
interface mrp_req_if;
   import mrp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CAND_WIDTH-1:0] candidate;
   modport source (output valid, output candidate, input ready);
   modport sink (input valid, input candidate, output ready);
endinterface

interface mrp_rsp_if;
   logic valid;
   logic ready;
   logic is_prime;
   modport source (output valid, output is_prime, input ready);
   modport sink (input valid, input is_prime, output ready);
endinterface

FILE: rtl/mrp_cell.sv
module mrp_cell (
   input  logic                 clock,
   input  mrp_pkg::cell_ctl_type ctl,
   input  logic                 y_load,
   input  logic                 y_prev,
   input  logic                 x_bit,
   input  logic                 m_bit,
   input  logic                 carry_in,
   input  logic                 borrow_in,
   output logic                 carry_out,
   output logic                 borrow_out,
   output logic                 acc_bit,
   output logic                 y_bit
);
   import mrp_pkg::*;

   logic acc_ff, acc_in;
   logic y_ff, y_in;
   logic b_bit, s_bit, t_bit;

   // One bit slice of the modular adder: sum, then the sum less the modulus.
   assign b_bit = ctl.dbl ? acc_ff : (x_bit & ctl.add_x);
   assign s_bit = acc_ff ^ b_bit ^ carry_in;
   assign carry_out = (acc_ff & b_bit) | (acc_ff & carry_in) | (b_bit & carry_in);
   assign t_bit = s_bit ^ m_bit ^ borrow_in;
   assign borrow_out = (~s_bit & m_bit) | (~s_bit & borrow_in) | (m_bit & borrow_in);

   always_comb begin
      acc_in = acc_ff;
      y_in = y_ff;
      if (ctl.load) begin
         acc_in = 1'b0;
         y_in = y_load;
      end else if (ctl.step) begin
         acc_in = ctl.use_diff ? t_bit : s_bit;
         if (ctl.shift) begin
            y_in = y_prev;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      y_ff <= y_in;
   end

   assign acc_bit = acc_ff;
   assign y_bit = y_ff;
endmodule

FILE: rtl/mrp_mulmod.sv
module mrp_mulmod (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  mrp_pkg::num_type x,
   input  mrp_pkg::num_type y,
   input  mrp_pkg::num_type m,
   output logic             done,
   output mrp_pkg::num_type product
);
   import mrp_pkg::*;

   num_type x_ff, x_in;
   num_type m_ff, m_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   cell_ctl_type ctl;
   logic [NUM_WIDTH:0] carry;
   logic [NUM_WIDTH:0] borrow;
   num_type acc;
   num_type ybits;

   assign carry[0] = 1'b0;
   assign borrow[0] = 1'b0;

   // Even steps double the accumulator, odd steps add x when the top bit
   // of y is set; the row shifts y left after each odd step.
   always_comb begin
      ctl.load = start;
      ctl.step = busy_ff;
      ctl.dbl = ~cnt_ff[0];
      ctl.add_x = ybits[NUM_WIDTH-1];
      ctl.shift = cnt_ff[0];
      ctl.use_diff = carry[NUM_WIDTH] | ~borrow[NUM_WIDTH];
   end

   for (genvar i = 0; i < NUM_WIDTH; i++) begin : g_cell
      mrp_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .y_load     (y[i]),
         .y_prev     ((i == 0) ? 1'b0 : ybits[(i == 0) ? 0 : i-1]),
         .x_bit      (x_ff[i]),
         .m_bit      (m_ff[i]),
         .carry_in   (carry[i]),
         .borrow_in  (borrow[i]),
         .carry_out  (carry[i+1]),
         .borrow_out (borrow[i+1]),
         .acc_bit    (acc[i]),
         .y_bit      (ybits[i])
      );
   end

   always_comb begin
      x_in = x_ff;
      m_in = m_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      if (start) begin
         x_in = x;
         m_in = m;
         busy_in = 1'b1;
         cnt_in = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(2 * NUM_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      x_ff <= x_in;
      m_ff <= m_in;
   end

   assign done = done_ff;
   assign product = acc;
endmodule

FILE: rtl/miller_rabin_prime_test_unit.sv
// Deterministic Miller-Rabin test of one 64-bit candidate per item, exact for
// every value. Every modular product runs through one row of 64 bit cells
// that doubles and conditionally adds for each multiplier bit. The residue
// mod 3, the seven base reductions, the exponentiations and the squarings
// all share that row. A candidate below 2 is answered in the cycle after it
// is taken; one that is even or divisible by 3 is answered once its residue
// mod 3 is known. A full test needs at most 1 + 7 * 128 = 897 products,
// because each base takes one reduction, at most 2 * (64 - s) products for
// the power and s squarings, where s >= 1 is the count of trailing zeros of
// candidate-1. One item is in flight at a time; the next is taken once the
// result has been accepted.
module miller_rabin_prime_test_unit (
   input logic       clock,
   input logic       reset,
   mrp_req_if.sink   req,
   mrp_rsp_if.source rsp
);
   import mrp_pkg::*;

   state_type state_ff, state_in;
   num_type n_ff, n_in;
   num_type d_ff, d_in;
   num_type pacc_ff, pacc_in;
   num_type base_ff, base_in;
   num_type expo_ff, expo_in;
   logic [S_W-1:0] s_ff, s_in;
   logic [S_W-1:0] left_ff, left_in;
   logic [WIDX_W-1:0] widx_ff, widx_in;
   logic moved_ff, moved_in;
   logic result_ff, result_in;

   logic mul_start, mul_done;
   num_type mul_x, mul_y, mul_m, mul_p;
   num_type nm1, one, cand_n;

   assign one = NUM_WIDTH'(1);
   assign nm1 = n_ff - one;
   assign cand_n = req.candidate[NUM_WIDTH-1:0];

   mrp_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .x       (mul_x),
      .y       (mul_y),
      .m       (mul_m),
      .done    (mul_done),
      .product (mul_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff <= n_in;
      d_ff <= d_in;
      pacc_ff <= pacc_in;
      base_ff <= base_in;
      expo_ff <= expo_in;
      s_ff <= s_in;
      left_ff <= left_in;
      widx_ff <= widx_in;
      moved_ff <= moved_in;
      result_ff <= result_in;
   end

   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      d_in = d_ff;
      pacc_in = pacc_ff;
      base_in = base_ff;
      expo_in = expo_ff;
      s_in = s_ff;
      left_in = left_ff;
      widx_in = widx_ff;
      moved_in = moved_ff;
      result_in = result_ff;
      mul_start = 1'b0;
      mul_x = pacc_ff;
      mul_y = base_ff;
      mul_m = n_ff;
      req.ready = 1'b0;
      rsp.valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               n_in = cand_n;
               if (cand_n[NUM_WIDTH-1:1] == '0) begin
                  result_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_MOD3;
               end
            end
         end
         ST_MOD3: begin
            // The row with x = 1 reduces y by the modulus.
            mul_start = 1'b1;
            mul_x = one;
            mul_y = n_ff;
            mul_m = NUM_WIDTH'(3);
            state_in = ST_MOD3_WAIT;
         end
         ST_MOD3_WAIT: begin
            if (mul_done) begin
               if (!n_ff[0] || mul_p == '0) begin
                  result_in = (n_ff == NUM_WIDTH'(2)) || (n_ff == NUM_WIDTH'(3));
                  state_in = ST_DONE;
               end else begin
                  d_in = nm1;
                  s_in = '0;
                  state_in = ST_SPLIT;
               end
            end
         end
         ST_SPLIT: begin
            if (!d_ff[0]) begin
               d_in = d_ff >> 1;
               s_in = s_ff + S_W'(1);
            end else begin
               widx_in = '0;
               state_in = ST_WIT;
            end
         end
         ST_WIT: begin
            mul_start = 1'b1;
            mul_x = one;
            mul_y = witness(widx_ff);
            state_in = ST_WIT_WAIT;
         end
         ST_WIT_WAIT: begin
            if (mul_done) begin
               if (mul_p == '0) begin
                  state_in = ST_NEXT;
               end else begin
                  pacc_in = one;
                  base_in = mul_p;
                  expo_in = d_ff;
                  state_in = ST_POW;
               end
            end
         end
         ST_POW: begin
            if (expo_ff == '0) begin
               left_in = s_ff;
               moved_in = 1'b0;
               state_in = ST_SQ_CHECK;
            end else if (expo_ff[0]) begin
               mul_start = 1'b1;
               state_in = ST_POW_MUL_WAIT;
            end else begin
               mul_start = 1'b1;
               mul_x = base_ff;
               state_in = ST_POW_SQR_WAIT;
            end
         end
         ST_POW_MUL_WAIT: begin
            if (mul_done) begin
               pacc_in = mul_p;
               mul_start = 1'b1;
               mul_x = base_ff;
               state_in = ST_POW_SQR_WAIT;
            end
         end
         ST_POW_SQR_WAIT: begin
            if (mul_done) begin
               base_in = mul_p;
               expo_in = expo_ff >> 1;
               state_in = ST_POW;
            end
         end
         ST_SQ_CHECK: begin
            if (pacc_ff == one || pacc_ff == nm1) begin
               // Reaching 1 after a squaring exposes a nontrivial root of 1.
               if (pacc_ff != nm1 && moved_ff) begin
                  result_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_NEXT;
               end
            end else begin
               moved_in = 1'b1;
               if (left_ff == '0) begin
                  result_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  left_in = left_ff - S_W'(1);
                  mul_start = 1'b1;
                  mul_y = pacc_ff;
                  state_in = ST_SQ_WAIT;
               end
            end
         end
         ST_SQ_WAIT: begin
            if (mul_done) begin
               pacc_in = mul_p;
               state_in = ST_SQ_CHECK;
            end
         end
         ST_NEXT: begin
            if (widx_ff == WIDX_W'(WIT_COUNT - 1)) begin
               result_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               widx_in = widx_ff + WIDX_W'(1);
               state_in = ST_WIT;
            end
         end
         ST_DONE: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp.is_prime = result_ff;
endmodule

FILE: rtl/mrp_checker.sv
module mrp_props (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_is_prime
);

   // A waiting result holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_prime))
      else $error("result item changed or dropped while stalled");

   // No item is taken while a result is still pending.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input accepted while a result waits");

   // Once an item is taken, no further item is taken in the next cycle.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while one is in flight");

   // No result is repeated: it is gone once delivered.
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("result repeated");

endmodule

bind miller_rabin_prime_test_unit mrp_props u_mrp_props (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_is_prime (rsp.is_prime)
);

FILE: bench/mrp_checker.sv
`timescale 1ns / 100ps

module mrp_checker (
   input  logic        clock,
   input  logic        reset,
   mrp_req_if          req,
   mrp_rsp_if          rsp,
   output int          fail_count,
   output int          pending_count,
   output int          prime_count,
   output int          result_count
);
   import mrp_pkg::*;

   localparam logic [63:0] BASES [7] = '{64'd2, 64'd325, 64'd9375, 64'd28178,
                                         64'd450775, 64'd9780504, 64'd1795265022};

   // Expected verdicts in order of acceptance, kept in a ring.
   bit verdicts [0:255];
   int wr_idx, rd_idx;

   function automatic num_type mul_mod(num_type a, num_type b, num_type m);
      logic [2*NUM_WIDTH-1:0] prod;
      prod = {{NUM_WIDTH{1'b0}}, a} * {{NUM_WIDTH{1'b0}}, b};
      return num_type'(prod % m);
   endfunction

   function automatic num_type pow_mod(num_type b, num_type e, num_type m);
      num_type acc;
      acc = num_type'(1);
      while (e != 0) begin
         if (e[0]) acc = mul_mod(acc, b, m);
         b = mul_mod(b, b, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic bit primality(logic [CAND_WIDTH-1:0] cand);
      num_type n, nm1, d, r, x;
      int s, left;
      bit moved;
      n = num_type'(cand);
      if (n < 2 || (n % 6) % 4 != 1) return (n | 1) == 3;
      nm1 = n - num_type'(1);
      d = nm1;
      s = 0;
      while (d[0] == 1'b0 && s < NUM_WIDTH) begin
         d = d >> 1;
         s++;
      end
      for (int k = 0; k < WIT_COUNT; k++) begin
         r = BASES[k] % n;
         if (r != 0) begin
            x = pow_mod(r, d, n);
            left = s;
            moved = 1'b0;
            while (x != 1 && x != nm1) begin
               moved = 1'b1;
               if (left == 0) break;
               left--;
               x = mul_mod(x, x, n);
            end
            if (x != nm1 && moved) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      bit want;
      if (reset) begin
         fail_count <= 0;
         prime_count <= 0;
         result_count <= 0;
         pending_count <= 0;
         wr_idx = 0;
         rd_idx = 0;
      end else begin
         if (req.valid && req.ready) begin
            want = primality(req.candidate);
            verdicts[wr_idx[7:0]] = want;
            wr_idx++;
            if (want) prime_count <= prime_count + 1;
         end
         if (rsp.valid && rsp.ready) begin
            result_count <= result_count + 1;
            if (wr_idx == rd_idx) begin
               $error("is_prime: no result expected, actual %0b", rsp.is_prime);
               fail_count <= fail_count + 1;
            end else begin
               want = verdicts[rd_idx[7:0]];
               rd_idx++;
               if (rsp.is_prime !== want) begin
                  $error("is_prime: expected %0b, actual %0b", want, rsp.is_prime);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= wr_idx - rd_idx;
      end
   end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
   import mrp_pkg::*;

   localparam int WATCHDOG_LIMIT = 1_000_000;
   localparam int RANDOM_ITEMS = 76;

   logic clock = 0;
   logic reset = 1;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   fail_count, pending_count, prime_count, result_count;
   int   quiet_cycles = 0;
   int   sent = 0;

   mrp_req_if req ();
   mrp_rsp_if rsp ();

   miller_rabin_prime_test_unit dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   mrp_checker checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .fail_count(fail_count), .pending_count(pending_count),
      .prime_count(prime_count), .result_count(result_count)
   );

   always #2 clock = ~clock;

   initial begin
      req.valid = 0;
      req.candidate = '0;
      rsp.ready = 0;
   end

   always @(negedge clock) begin
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL miller_rabin_prime_test_unit");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The valid line stays high from one item to the next unless an idle gap is drawn.
   // Ready depends only on the block's state, so it is settled at the falling edge.
   task automatic send_candidate(logic [63:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid = 0;
         @(negedge clock);
      end
      req.valid = 1;
      req.candidate = value;
      while (!req.ready) @(negedge clock);
      @(negedge clock);
      sent++;
   endtask

   function automatic logic [63:0] random_candidate();
      logic [31:0] p, q;
      case ($urandom_range(4))
         0: return {$urandom, $urandom} | 64'd1;
         1: return 64'($urandom_range(1000));
         2: begin
            // Odd products; those prime to 3 run the whole first exponentiation.
            p = $urandom | 32'd1;
            q = $urandom | 32'd1;
            return 64'(p) * 64'(q);
         end
         3: return {$urandom, $urandom};
         default: return (64'($urandom_range(20_000_000)) << $urandom_range(40)) + 64'd1;
      endcase
   endfunction

   initial begin
      logic [63:0] directed [] = '{
         64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd7, 64'd9, 64'd13, 64'd25,
         64'd561, 64'd2047, 64'd3215031751, 64'd341550071728321, 64'd1000000007,
         64'd998244353, 64'h1_0000_0001, 64'h1FFF_FFFF_FFFF_FFFF,
         64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFF,
         64'd1795265022, 64'd1795265023, 64'd325};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      send_idle_pct = 18;
      recv_stall_pct = 54;
      foreach (directed[i]) send_candidate(directed[i]);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) begin
            send_idle_pct = 54;
            recv_stall_pct = 18;
         end else if (i == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         send_candidate(random_candidate());
      end
      req.valid = 0;

      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Tested %0d candidates, %0d of them prime, %0d verdicts checked.",
               sent, prime_count, result_count);
      if (fail_count == 0) begin
         $display("PASS miller_rabin_prime_test_unit");
      end else begin
         $display("FAIL miller_rabin_prime_test_unit");
      end
      $finish;
   end

endmodule
